FILE: design/bdpa_pkg.sv
// shared codes, types and defaults for the binary delta patch applier
package bdpa_pkg;

  localparam int OLD_DEPTH_DEF = 65536;
  localparam int APB_AW = 3;

  localparam logic [1:0] FUNC_LOAD   = 2'd0;
  localparam logic [1:0] FUNC_CTRL   = 2'd1;
  localparam logic [1:0] FUNC_DATA   = 2'd2;
  localparam logic [1:0] FUNC_FINISH = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_ADD_OVR  = 3'd1;
  localparam logic [2:0] ST_COPY_OVR = 3'd2;
  localparam logic [2:0] ST_NEG      = 3'd3;
  localparam logic [2:0] ST_SIZE     = 3'd4;
  localparam logic [2:0] ST_UNEXP    = 3'd5;

  typedef struct packed {
    logic [31:0] new_size;
    logic [16:0] old_size;
  } cfg_t;

  typedef struct packed {
    logic        we;
    logic        re;
  } mem_ctl_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [31:0] pos;
    logic [2:0]  status;
    logic        add_en;
  } mid_t;

endpackage

FILE: design/bdpa_in_if.sv
// input channel: one patch item per beat
interface bdpa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] old_index;
  logic [7:0]  byte_value;
  logic [63:0] ctrl_add_raw;
  logic [63:0] ctrl_copy_raw;
  logic [63:0] ctrl_seek_raw;

  modport source (
    output valid, func, old_index, byte_value, ctrl_add_raw, ctrl_copy_raw, ctrl_seek_raw,
    input  ready
  );
  modport sink (
    input  valid, func, old_index, byte_value, ctrl_add_raw, ctrl_copy_raw, ctrl_seek_raw,
    output ready
  );
endinterface

FILE: design/bdpa_out_if.sv
// output channel: one result per beat
interface bdpa_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  new_byte;
  logic [31:0] new_position;
  logic [2:0]  status;

  modport source (
    output valid, kind, new_byte, new_position, status,
    input  ready
  );
  modport sink (
    input  valid, kind, new_byte, new_position, status,
    output ready
  );
endinterface

FILE: design/binary_delta_patch_apply.sv
// top level of the binary delta patch applier
// Applies a bsdiff-style delta one item per beat: old-image bytes are loaded into an internal
// store of OLD_DEPTH bytes, control beats set up add and copy runs, data beats produce one
// patched byte each and a finish beat checks the final size. Every input beat gives exactly one
// result beat. The block takes one beat per cycle unless the result side stalls it; a beat
// passes through the input register, the state update with the store read and the result
// register. The old store has a registered read: the old byte arrives in the cycle after its
// address. The store is not cleared at reset and needs no clearing pass; bytes read from it
// must have been loaded first. Registers new_size (offset 0) and old_size (offset 4) are
// written by the user over the apb port only while the block is idle; nothing enforces it.
module binary_delta_patch_apply #(
  parameter int OLD_DEPTH = bdpa_pkg::OLD_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  bdpa_in_if.sink                      patch_in,
  bdpa_out_if.source                   patch_out,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bdpa_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int AW = (OLD_DEPTH > 1) ? $clog2(OLD_DEPTH) : 1;

  bdpa_pkg::cfg_t     cfg;
  bdpa_pkg::mem_ctl_t mem_ctl;
  logic [AW-1:0]      mem_waddr;
  logic [7:0]         mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [7:0]         rd_data;
  logic               mid_valid;
  logic               mid_ready;
  bdpa_pkg::mid_t     mid;

  bdpa_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bdpa_core #(.OLD_DEPTH(OLD_DEPTH)) u_core (
    .clk       (clk),
    .rst       (rst),
    .patch_in  (patch_in),
    .cfg       (cfg),
    .mem_ctl   (mem_ctl),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mid_valid (mid_valid),
    .mid       (mid),
    .mid_ready (mid_ready)
  );

  bdpa_store #(.OLD_DEPTH(OLD_DEPTH)) u_store (
    .clk     (clk),
    .ctl     (mem_ctl),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr   (mem_raddr),
    .rd_data (rd_data)
  );

  bdpa_out u_out (
    .clk       (clk),
    .rst       (rst),
    .mid_valid (mid_valid),
    .mid       (mid),
    .rd_data   (rd_data),
    .mid_ready (mid_ready),
    .patch_out (patch_out)
  );

endmodule

FILE: design/bdpa_cfg.sv
// apb register file holding the expected new size and the old image size
module bdpa_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bdpa_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output bdpa_pkg::cfg_t               cfg
);

  localparam logic REG_NEW_SIZE = 1'b0;
  localparam logic REG_OLD_SIZE = 1'b1;

  logic [31:0] new_size;
  logic [16:0] old_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      new_size <= '0;
      old_size <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_NEW_SIZE: new_size <= pwdata;
        REG_OLD_SIZE: old_size <= pwdata[16:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_NEW_SIZE: prdata = new_size;
      REG_OLD_SIZE: prdata = {15'd0, old_size};
    endcase
  end

  assign pready       = 1'b1;
  assign cfg.new_size = new_size;
  assign cfg.old_size = old_size;

endmodule

FILE: design/bdpa_store.sv
// old image store with registered read
module bdpa_store #(
  parameter int OLD_DEPTH = bdpa_pkg::OLD_DEPTH_DEF,
  localparam int AW = (OLD_DEPTH > 1) ? $clog2(OLD_DEPTH) : 1
) (
  input  logic                 clk,
  input  bdpa_pkg::mem_ctl_t   ctl,
  input  logic [AW-1:0]        waddr,
  input  logic [7:0]           wdata,
  input  logic [AW-1:0]        raddr,
  output logic [7:0]           rd_data
);

  logic [7:0] mem [OLD_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
    if (ctl.re) begin
      rd_data <= mem[raddr];
    end
  end

endmodule

FILE: design/bdpa_core.sv
// input stage, patch state and per-item decode feeding the middle stage
module bdpa_core #(
  parameter int OLD_DEPTH = bdpa_pkg::OLD_DEPTH_DEF,
  localparam int AW = (OLD_DEPTH > 1) ? $clog2(OLD_DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  bdpa_in_if.sink              patch_in,
  input  bdpa_pkg::cfg_t       cfg,
  output bdpa_pkg::mem_ctl_t   mem_ctl,
  output logic [AW-1:0]        mem_waddr,
  output logic [7:0]           mem_wdata,
  output logic [AW-1:0]        mem_raddr,
  output logic                 mid_valid,
  output bdpa_pkg::mid_t       mid,
  input  logic                 mid_ready
);

  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_ADD  = 2'd1;
  localparam logic [1:0] PH_COPY = 2'd2;

  // input register
  logic        v1;
  logic [1:0]  f_func;
  logic [15:0] f_index;
  logic [7:0]  f_byte;
  logic [63:0] f_add;
  logic [63:0] f_copy;
  logic [63:0] f_seek;
  logic        adv1;

  // patch state
  logic [63:0] old_pos, old_pos_next;
  logic [31:0] new_pos, new_pos_next;
  logic [31:0] add_left, add_left_next;
  logic [31:0] copy_left, copy_left_next;
  logic [63:0] seek_pending, seek_pending_next;
  logic [1:0]  phase, phase_next;
  logic        err, err_next;

  bdpa_pkg::mid_t mid_next;

  logic [62:0] add_mag;
  logic [62:0] copy_mag;
  logic        add_neg;
  logic        copy_neg;
  logic [31:0] room;
  logic [31:0] copy_room;
  logic        add_ovr;
  logic        copy_ovr;
  logic [63:0] seek_val;
  logic        lim_cap;
  logic [16:0] lim;
  logic        in_range;
  logic        idx_ok;
  logic [63:0] pos_step;
  logic        pos_inc;
  logic        pos_clear;

  assign adv1           = v1 && (!mid_valid || mid_ready);
  assign patch_in.ready = !v1 || adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (patch_in.ready) begin
      v1 <= patch_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (patch_in.valid && patch_in.ready) begin
      f_func  <= patch_in.func;
      f_index <= patch_in.old_index;
      f_byte  <= patch_in.byte_value;
      f_add   <= patch_in.ctrl_add_raw;
      f_copy  <= patch_in.ctrl_copy_raw;
      f_seek  <= patch_in.ctrl_seek_raw;
    end
  end

  // length and bound checks
  assign add_mag   = f_add[62:0];
  assign copy_mag  = f_copy[62:0];
  assign add_neg   = f_add[63] && (add_mag != '0);
  assign copy_neg  = f_copy[63] && (copy_mag != '0);
  assign room      = (cfg.new_size >= new_pos) ? (cfg.new_size - new_pos) : '0;
  assign add_ovr   = (add_mag[62:32] != '0) || (add_mag[31:0] > room);
  assign copy_room = room - add_mag[31:0];
  assign copy_ovr  = (copy_mag[62:32] != '0) || (copy_mag[31:0] > copy_room);
  assign seek_val  = f_seek[63] ? (64'd0 - {1'b0, f_seek[62:0]}) : {1'b0, f_seek[62:0]};

  // old position window
  assign lim_cap  = {15'd0, cfg.old_size} > 32'(OLD_DEPTH);
  assign lim      = lim_cap ? 17'(OLD_DEPTH) : cfg.old_size;
  assign in_range = (old_pos[63:17] == '0) && (old_pos[16:0] < lim);
  assign idx_ok   = {16'd0, f_index} < 32'(OLD_DEPTH);

  always_comb begin
    new_pos_next      = new_pos;
    add_left_next     = add_left;
    copy_left_next    = copy_left;
    seek_pending_next = seek_pending;
    phase_next        = phase;
    err_next          = err;
    pos_step          = '0;
    pos_inc           = 1'b0;
    pos_clear         = 1'b0;
    mem_ctl.we        = 1'b0;
    mem_ctl.re        = adv1;
    mid_next.kind      = 1'b0;
    mid_next.data_byte = '0;
    mid_next.pos       = new_pos;
    mid_next.status    = bdpa_pkg::ST_OK;
    mid_next.add_en    = 1'b0;

    unique case (f_func)
      bdpa_pkg::FUNC_LOAD: begin
        mem_ctl.we = adv1 && idx_ok;
      end
      bdpa_pkg::FUNC_CTRL: begin
        priority if (err || phase != PH_WAIT) begin
          mid_next.status = bdpa_pkg::ST_UNEXP;
        end else if (add_neg || copy_neg) begin
          err_next        = 1'b1;
          mid_next.status = bdpa_pkg::ST_NEG;
        end else if (add_ovr) begin
          err_next        = 1'b1;
          mid_next.status = bdpa_pkg::ST_ADD_OVR;
        end else if (copy_ovr) begin
          err_next        = 1'b1;
          mid_next.status = bdpa_pkg::ST_COPY_OVR;
        end else begin
          add_left_next  = add_mag[31:0];
          copy_left_next = copy_mag[31:0];
          priority if (add_mag[31:0] != '0) begin
            seek_pending_next = seek_val;
            phase_next        = PH_ADD;
          end else if (copy_mag[31:0] != '0) begin
            seek_pending_next = seek_val;
            phase_next        = PH_COPY;
          end else begin
            // empty segment: seek at once
            pos_step          = seek_val;
            seek_pending_next = '0;
            phase_next        = PH_WAIT;
          end
        end
      end
      bdpa_pkg::FUNC_DATA: begin
        if (err || phase == PH_WAIT) begin
          mid_next.status = bdpa_pkg::ST_UNEXP;
        end else begin
          mid_next.kind      = 1'b1;
          mid_next.data_byte = f_byte;
          new_pos_next       = new_pos + 32'd1;
          if (phase == PH_ADD) begin
            mid_next.add_en = in_range;
            pos_inc         = 1'b1;
            add_left_next   = add_left - 32'd1;
            if (add_left == 32'd1) begin
              if (copy_left != '0) begin
                phase_next = PH_COPY;
              end else begin
                pos_step          = seek_pending;
                seek_pending_next = '0;
                phase_next        = PH_WAIT;
              end
            end
          end else begin
            copy_left_next = copy_left - 32'd1;
            if (copy_left == 32'd1) begin
              pos_step          = seek_pending;
              seek_pending_next = '0;
              phase_next        = PH_WAIT;
            end
          end
        end
      end
      bdpa_pkg::FUNC_FINISH: begin
        if (err || phase != PH_WAIT || new_pos != cfg.new_size) begin
          mid_next.status = bdpa_pkg::ST_SIZE;
        end
        mid_next.pos      = '0;
        pos_clear         = 1'b1;
        new_pos_next      = '0;
        add_left_next     = '0;
        copy_left_next    = '0;
        seek_pending_next = '0;
        phase_next        = PH_WAIT;
        err_next          = 1'b0;
      end
    endcase

    old_pos_next = pos_clear ? '0 : (old_pos + pos_step + {63'd0, pos_inc});
  end

  assign mem_waddr = AW'(f_index);
  assign mem_wdata = f_byte;
  assign mem_raddr = AW'(old_pos[16:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      old_pos      <= '0;
      new_pos      <= '0;
      add_left     <= '0;
      copy_left    <= '0;
      seek_pending <= '0;
      phase        <= PH_WAIT;
      err          <= 1'b0;
    end else if (adv1) begin
      old_pos      <= old_pos_next;
      new_pos      <= new_pos_next;
      add_left     <= add_left_next;
      copy_left    <= copy_left_next;
      seek_pending <= seek_pending_next;
      phase        <= phase_next;
      err          <= err_next;
    end
  end

  // middle stage
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (!mid_valid || mid_ready) begin
      mid_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      mid <= mid_next;
    end
  end

endmodule

FILE: design/bdpa_out.sv
// byte add with the old store data and the result register
module bdpa_out (
  input  logic           clk,
  input  logic           rst,
  input  logic           mid_valid,
  input  bdpa_pkg::mid_t mid,
  input  logic [7:0]     rd_data,
  output logic           mid_ready,
  bdpa_out_if.source     patch_out
);

  logic        v3;
  logic        kind;
  logic [7:0]  new_byte;
  logic [31:0] new_position;
  logic [2:0]  status;

  assign mid_ready = !v3 || patch_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (mid_ready) begin
      v3 <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_valid && mid_ready) begin
      kind         <= mid.kind;
      new_byte     <= mid.add_en ? (mid.data_byte + rd_data) : mid.data_byte;
      new_position <= mid.pos;
      status       <= mid.status;
    end
  end

  assign patch_out.valid        = v3;
  assign patch_out.kind         = kind;
  assign patch_out.new_byte     = new_byte;
  assign patch_out.new_position = new_position;
  assign patch_out.status       = status;

endmodule

FILE: design/bdpa_checker.sv
// port-level checks on the patch applier results, bound to the top level
module bdpa_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        kind,
  input logic [7:0]  new_byte,
  input logic [2:0]  status
);

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind |-> status == bdpa_pkg::ST_OK)
    else $error("byte result with error status");

  a_status_zero_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && !kind |-> new_byte == 8'd0)
    else $error("status result carries a byte");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= bdpa_pkg::ST_UNEXP)
    else $error("status code out of range");

endmodule

bind binary_delta_patch_apply bdpa_checker u_bdpa_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (patch_out.valid),
  .out_ready (patch_out.ready),
  .kind      (patch_out.kind),
  .new_byte  (patch_out.new_byte),
  .status    (patch_out.status)
);

FILE: sim/tb_binary_delta_patch_apply.sv
// testbench for the binary delta patch applier: scripted patch beats, then random patches
module tb_binary_delta_patch_apply;
  import bdpa_pkg::*;

  localparam int STORE_DEPTH = OLD_DEPTH_DEF;
  localparam int REG_NEW_SIZE = 0;
  localparam int REG_OLD_SIZE = 1;
  localparam int ITEM_TARGET = 1700;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 12;
  localparam logic [63:0] SIGN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ALL1 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MAXP = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {AWAIT_CTRL, ADDING, COPYING} seg_phase_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] idx;
    logic [7:0]  val;
    logic [63:0] add_raw;
    logic [63:0] copy_raw;
    logic [63:0] seek_raw;
  } beat_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  nbyte;
    logic [31:0] pos;
    logic [2:0]  status;
  } res_t;

  typedef struct packed {
    logic        wr;
    logic [1:0]  func;
    logic [15:0] idx;
    logic [7:0]  val;
    logic [63:0] add_raw;
    logic [63:0] copy_raw;
    logic [63:0] seek_raw;
    logic        chk;
    logic [31:0] pos;
    logic [2:0]  st;
  } script_row_t;

  // register rows carry new_size in the add column and old_size in the copy column
  localparam script_row_t PATCH_SCRIPT [0:27] = '{
    '{0, FUNC_DATA,   16'h0, 8'h00, 64'd0, 64'd0, 64'd0,    1, 32'd0, ST_UNEXP},
    '{0, FUNC_FINISH, 16'h0, 8'h00, 64'd0, 64'd0, 64'd0,    1, 32'd0, ST_OK},
    '{0, FUNC_CTRL,   16'h0, 8'h00, SIGN,  64'd0, 64'd0,    1, 32'd0, ST_OK},
    '{0, FUNC_CTRL,   16'h0, 8'h00, 64'd1, 64'd0, 64'd0,    1, 32'd0, ST_ADD_OVR},
    '{0, FUNC_CTRL,   16'h0, 8'h00, 64'd0, 64'd0, 64'd0,    1, 32'd0, ST_UNEXP},
    '{0, FUNC_FINISH, 16'h0, 8'h00, 64'd0, 64'd0, 64'd0,    1, 32'd0, ST_SIZE},
    '{0, FUNC_CTRL,   16'h0, 8'h00, 64'd0, 64'd1, 64'd0,    1, 32'd0, ST_COPY_OVR},
    '{0, FUNC_FINISH, 16'h0, 8'h00, 64'd0, 64'd0, 64'd0,    1, 32'd0, ST_SIZE},
    '{0, FUNC_CTRL,   16'h0, 8'h00, 64'd1, ALL1,  64'd0,    1, 32'd0, ST_NEG},
    '{0, FUNC_FINISH, 16'h0, 8'h00, 64'd0, 64'd0, 64'd0,    1, 32'd0, ST_SIZE},
    '{1, FUNC_LOAD,   16'h0, 8'h00, 64'd8, 64'd4, 64'd0,    0, 32'd0, ST_OK},
    '{0, FUNC_LOAD,   16'h0, 8'hFF, 64'd0, 64'd0, 64'd0,    1, 32'd0, ST_OK},
    '{0, FUNC_LOAD,   16'h1, 8'h01, 64'd0, 64'd0, 64'd0,    1, 32'd0, ST_OK},
    '{0, FUNC_LOAD,   16'h2, 8'h80, 64'd0, 64'd0, 64'd0,    1, 32'd0, ST_OK},
    '{0, FUNC_LOAD,   16'h3, 8'h7F, 64'd0, 64'd0, 64'd0,    1, 32'd0, ST_OK},
    '{0, FUNC_CTRL,   16'h0, 8'h00, 64'd5, 64'd1, SIGN | 3, 1, 32'd0, ST_OK},
    '{0, FUNC_CTRL,   16'h0, 8'h00, 64'd0, 64'd0, 64'd0,    1, 32'd0, ST_UNEXP},
    '{0, FUNC_DATA,   16'h0, 8'h01, 64'd0, 64'd0, 64'd0,    0, 32'd0, ST_OK},
    '{0, FUNC_DATA,   16'h0, 8'hFF, 64'd0, 64'd0, 64'd0,    0, 32'd0, ST_OK},
    '{0, FUNC_DATA,   16'h0, 8'h80, 64'd0, 64'd0, 64'd0,    0, 32'd0, ST_OK},
    '{0, FUNC_DATA,   16'h0, 8'h00, 64'd0, 64'd0, 64'd0,    0, 32'd0, ST_OK},
    '{0, FUNC_DATA,   16'h0, 8'h55, 64'd0, 64'd0, 64'd0,    0, 32'd0, ST_OK},
    '{0, FUNC_DATA,   16'h0, 8'hFF, 64'd0, 64'd0, 64'd0,    0, 32'd0, ST_OK},
    '{0, FUNC_CTRL,   16'h0, 8'h00, 64'd0, 64'd0, SIGN | 3, 1, 32'd6, ST_OK},
    '{0, FUNC_CTRL,   16'h0, 8'h00, 64'd2, 64'd0, MAXP,     1, 32'd6, ST_OK},
    '{0, FUNC_DATA,   16'h0, 8'hFF, 64'd0, 64'd0, 64'd0,    0, 32'd0, ST_OK},
    '{0, FUNC_DATA,   16'h0, 8'h00, 64'd0, 64'd0, 64'd0,    0, 32'd0, ST_OK},
    '{0, FUNC_FINISH, 16'h0, 8'h00, 64'd0, 64'd0, 64'd0,    1, 32'd0, ST_OK}
  };

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  bdpa_in_if patch_in_bus ();
  bdpa_out_if patch_out_bus ();

  binary_delta_patch_apply dut (
    .clk(clk),
    .rst(rst),
    .patch_in(patch_in_bus),
    .patch_out(patch_out_bus),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // patch state as the block should hold it
  logic [7:0] img_old [STORE_DEPTH];
  bit img_loaded [STORE_DEPTH];
  logic [63:0] src_pos;
  logic [63:0] add_owed;
  logic [63:0] copy_owed;
  logic [63:0] seek_held;
  logic [31:0] dst_pos;
  seg_phase_e seg_phase;
  logic fault;
  logic [31:0] cfg_new_size;
  logic [16:0] cfg_old_size;

  res_t patch_results[$];
  int fail_count = 0;
  int sent_beats = 0;
  int idle_cycles = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  function automatic logic is_neg(logic [63:0] w);
    return w[63] && (w[62:0] != '0);
  endfunction

  function automatic logic [63:0] old_limit();
    return (int'(cfg_old_size) > STORE_DEPTH) ? 64'(STORE_DEPTH) : 64'(cfg_old_size);
  endfunction

  function automatic void close_segment();
    src_pos = src_pos + seek_held;
    seek_held = '0;
    seg_phase = AWAIT_CTRL;
  endfunction

  function automatic void clear_patch();
    src_pos = '0;
    dst_pos = '0;
    add_owed = '0;
    copy_owed = '0;
    seek_held = '0;
    seg_phase = AWAIT_CTRL;
    fault = 1'b0;
  endfunction

  function automatic res_t apply_patch_beat(beat_t b);
    res_t r;
    logic [63:0] addn;
    logic [63:0] copyn;
    logic [63:0] room;
    logic bad;
    r = '0;
    r.pos = dst_pos;
    r.status = ST_OK;
    addn = {1'b0, b.add_raw[62:0]};
    copyn = {1'b0, b.copy_raw[62:0]};
    room = (cfg_new_size >= dst_pos) ? 64'(cfg_new_size - dst_pos) : '0;
    case (b.func)
      FUNC_LOAD: begin
        img_old[b.idx] = b.val;
        img_loaded[b.idx] = 1'b1;
      end
      FUNC_CTRL: begin
        if (fault || seg_phase != AWAIT_CTRL) begin
          r.status = ST_UNEXP;
        end else if (is_neg(b.add_raw) || is_neg(b.copy_raw)) begin
          fault = 1'b1;
          r.status = ST_NEG;
        end else if (addn > room) begin
          fault = 1'b1;
          r.status = ST_ADD_OVR;
        end else if (copyn > room - addn) begin
          fault = 1'b1;
          r.status = ST_COPY_OVR;
        end else begin
          add_owed = addn;
          copy_owed = copyn;
          seek_held = is_neg(b.seek_raw) ? 64'd0 - {1'b0, b.seek_raw[62:0]}
                                         : {1'b0, b.seek_raw[62:0]};
          if (addn != 0) seg_phase = ADDING;
          else if (copyn != 0) seg_phase = COPYING;
          else close_segment();
        end
      end
      FUNC_DATA: begin
        if (fault || seg_phase == AWAIT_CTRL) begin
          r.status = ST_UNEXP;
        end else begin
          r.kind = 1'b1;
          r.nbyte = b.val;
          if (seg_phase == ADDING) begin
            if (src_pos < old_limit()) r.nbyte = b.val + img_old[src_pos[15:0]];
            src_pos = src_pos + 1;
            add_owed = add_owed - 1;
            if (add_owed == 0) begin
              if (copy_owed != 0) seg_phase = COPYING;
              else close_segment();
            end
          end else begin
            copy_owed = copy_owed - 1;
            if (copy_owed == 0) close_segment();
          end
          dst_pos = dst_pos + 1;
        end
      end
      default: begin
        bad = fault || seg_phase != AWAIT_CTRL || dst_pos != cfg_new_size;
        clear_patch();
        r.pos = dst_pos;
        r.status = bad ? ST_SIZE : ST_OK;
      end
    endcase
    return r;
  endfunction

  function automatic beat_t rand_beat(logic [1:0] func);
    beat_t b;
    b.func = func;
    b.idx = 16'($urandom);
    b.val = 8'($urandom);
    b.add_raw = {$urandom, $urandom};
    b.copy_raw = {$urandom, $urandom};
    b.seek_raw = {$urandom, $urandom};
    return b;
  endfunction

  task automatic push_beat(beat_t b, logic chk, res_t typed);
    int gap;
    res_t predicted;
    gap = tx_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      patch_in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    patch_in_bus.func <= b.func;
    patch_in_bus.old_index <= b.idx;
    patch_in_bus.byte_value <= b.val;
    patch_in_bus.ctrl_add_raw <= b.add_raw;
    patch_in_bus.ctrl_copy_raw <= b.copy_raw;
    patch_in_bus.ctrl_seek_raw <= b.seek_raw;
    patch_in_bus.valid <= 1'b1;
    do @(posedge clk); while (!(patch_in_bus.valid && patch_in_bus.ready));
    predicted = apply_patch_beat(b);
    sent_beats++;
    patch_results.push_back(chk ? typed : predicted);
  endtask

  // an add byte never reads a store entry that was not loaded
  task automatic send_beat(beat_t b, logic chk, res_t typed);
    beat_t fill;
    if (b.func == FUNC_DATA && !fault && seg_phase == ADDING && src_pos < old_limit()
        && !img_loaded[src_pos[15:0]]) begin
      fill = rand_beat(FUNC_LOAD);
      fill.idx = src_pos[15:0];
      push_beat(fill, 1'b0, '0);
    end
    push_beat(b, chk, typed);
  endtask

  task automatic maybe_noise();
    if ($urandom_range(0, 24) == 0) send_beat(rand_beat(2'($urandom_range(0, 3))), 1'b0, '0);
  endtask

  task automatic settle();
    patch_in_bus.valid <= 1'b0;
    @(posedge clk);
    while (patch_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(int index, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'(index * 4);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (index == REG_NEW_SIZE) cfg_new_size = value;
    else cfg_old_size = value[16:0];
  endtask

  task automatic program_sizes(logic [31:0] new_size, logic [31:0] old_size);
    write_reg(REG_NEW_SIZE, new_size);
    write_reg(REG_OLD_SIZE, old_size);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random_patch();
    int nseg;
    int pick;
    logic [31:0] total;
    logic [31:0] new_choice;
    logic [16:0] old_choice;
    logic [63:0] add_q[$];
    logic [63:0] copy_q[$];
    logic [63:0] seek_q[$];
    int bytes_q[$];
    beat_t b;
    settle();
    tx_calm = ($urandom_range(0, 3) == 0);
    nseg = $urandom_range(1, 4);
    total = '0;
    for (int s = 0; s < nseg; s++) begin
      if ($urandom_range(0, 19) == 0) begin
        // long run, cut short by the finish
        add_q.push_back({32'h0, $urandom});
        copy_q.push_back(64'($urandom_range(0, 8)));
        bytes_q.push_back($urandom_range(0, 5));
      end else begin
        add_q.push_back(64'($urandom_range(0, 12)));
        copy_q.push_back(64'($urandom_range(0, 8)));
        bytes_q.push_back(int'(add_q[s] + copy_q[s]));
      end
      total = total + 32'(add_q[s] + copy_q[s]);
      pick = $urandom_range(0, 9);
      if (pick == 0) seek_q.push_back({$urandom, $urandom});
      else if (pick == 1) seek_q.push_back(SIGN);
      else seek_q.push_back({1'($urandom), 63'($urandom_range(0, 20))});
    end
    pick = $urandom_range(0, 9);
    case (pick)
      0: new_choice = '0;
      1: new_choice = 32'hFFFF_FFFF;
      2: new_choice = total + 32'($urandom_range(1, 3));
      3: new_choice = total - 1;
      4: new_choice = $urandom;
      default: new_choice = total;
    endcase
    pick = $urandom_range(0, 9);
    case (pick)
      0: old_choice = '0;
      1: old_choice = 17'(STORE_DEPTH);
      2: old_choice = 17'h1FFFF;
      3: old_choice = 17'($urandom_range(STORE_DEPTH + 1, 131071));
      4: old_choice = 17'd1;
      default: old_choice = 17'($urandom_range(2, 80));
    endcase
    program_sizes(new_choice, 32'(old_choice));
    repeat ($urandom_range(0, 6)) begin
      b = rand_beat(FUNC_LOAD);
      if ($urandom_range(0, 3) != 0) b.idx = 16'($urandom_range(0, 63));
      send_beat(b, 1'b0, '0);
    end
    for (int s = 0; s < nseg; s++) begin
      maybe_noise();
      b = rand_beat(FUNC_CTRL);
      b.add_raw = add_q[s];
      b.copy_raw = copy_q[s];
      b.seek_raw = seek_q[s];
      send_beat(b, 1'b0, '0);
      for (int k = 0; k < bytes_q[s]; k++) begin
        maybe_noise();
        send_beat(rand_beat(FUNC_DATA), 1'b0, '0);
      end
    end
    // now and then the patch stays open into the next size setting
    if ($urandom_range(0, 5) != 0) send_beat(rand_beat(FUNC_FINISH), 1'b0, '0);
  endtask

  task automatic flag_mismatch(res_t want, res_t got, bit orphan);
    fail_count++;
    if (fail_count <= 10) begin
      if (orphan)
        $display("result with nothing pending: kind=%0d byte=%02h pos=%0d status=%0d",
                 got.kind, got.nbyte, got.pos, got.status);
      else
        $display("mismatch: want kind=%0d byte=%02h pos=%0d status=%0d, got kind=%0d %s",
                 want.kind, want.nbyte, want.pos, want.status, got.kind,
                 $sformatf("byte=%02h pos=%0d status=%0d", got.nbyte, got.pos, got.status));
    end
  endtask

  always @(posedge clk) begin : result_check
    res_t want;
    res_t got;
    if (!rst && patch_out_bus.valid && patch_out_bus.ready) begin
      got.kind = patch_out_bus.kind;
      got.nbyte = patch_out_bus.new_byte;
      got.pos = patch_out_bus.new_position;
      got.status = patch_out_bus.status;
      if (patch_results.size() == 0) begin
        flag_mismatch('0, got, 1'b1);
      end else begin
        want = patch_results.pop_front();
        if (got.kind !== want.kind || got.nbyte !== want.nbyte || got.pos !== want.pos
            || got.status !== want.status) flag_mismatch(want, got, 1'b0);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (patch_in_bus.valid && patch_in_bus.ready)
        || (patch_out_bus.valid && patch_out_bus.ready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : result_sink
    int wait_cycles;
    patch_out_bus.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      wait_cycles = rx_calm ? 0 : $urandom_range(0, 10);
      if (wait_cycles > 0) begin
        patch_out_bus.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      patch_out_bus.ready <= 1'b1;
      do @(posedge clk); while (!(patch_out_bus.valid && patch_out_bus.ready));
    end
  end

  initial begin : stimulus
    script_row_t row;
    beat_t b;
    res_t typed;
    rst <= 1'b1;
    patch_in_bus.valid <= 1'b0;
    patch_in_bus.func <= FUNC_LOAD;
    patch_in_bus.old_index <= '0;
    patch_in_bus.byte_value <= '0;
    patch_in_bus.ctrl_add_raw <= '0;
    patch_in_bus.ctrl_copy_raw <= '0;
    patch_in_bus.ctrl_seek_raw <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    clear_patch();
    cfg_new_size = '0;
    cfg_old_size = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (PATCH_SCRIPT[i]) begin
      row = PATCH_SCRIPT[i];
      if (row.wr) begin
        settle();
        program_sizes(row.add_raw[31:0], row.copy_raw[31:0]);
      end else begin
        b.func = row.func;
        b.idx = row.idx;
        b.val = row.val;
        b.add_raw = row.add_raw;
        b.copy_raw = row.copy_raw;
        b.seek_raw = row.seek_raw;
        typed.kind = 1'b0;
        typed.nbyte = 8'h00;
        typed.pos = row.pos;
        typed.status = row.st;
        send_beat(b, row.chk, typed);
      end
    end

    sent_beats = 0;
    while (sent_beats < ITEM_TARGET) run_random_patch();

    settle();
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
